@@ rtl/aes_pkg.sv @@
// aes_pkg: shared types, s-box table and round helper functions for the aes-128 pipeline
// no dependencies
`timescale 1ns / 1ps
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int BLOCK_W    = 128;
    localparam int FIELD_W    = 64;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [7:0]         t_byte;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // byte i of the state sits at bits 127-8i
    function automatic t_byte get_byte(t_block b, int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic t_byte gf_dbl(t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    // round constant for round r (1..10)
    function automatic t_byte rcon(int r);
        t_byte c;
        c = 8'h01;
        for (int j = 1; j < r; j++) c = gf_dbl(c);
        return c;
    endfunction

endpackage

@@ rtl/aes_round.sv @@
// aes_round: one registered aes round plus key expansion step
// depends on aes_pkg
`timescale 1ns / 1ps
module aes_round #(
    parameter int ROUND  = 1,
    parameter int ROUNDS = aes_pkg::NUM_ROUNDS
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  aes_pkg::t_block i_state,
    input  aes_pkg::t_block i_key,
    output aes_pkg::t_block o_state,
    output aes_pkg::t_block o_key
);
    import aes_pkg::*;

    localparam t_byte RC = rcon(ROUND);

    t_byte  k   [16];
    t_byte  nk  [16];
    t_byte  ss  [16];
    t_byte  ms  [16];
    t_byte  tw  [4];
    t_block n_state;
    t_block n_key;
    t_block r_state;
    t_block r_key;

    always_comb begin
        for (int i = 0; i < 16; i++) k[i] = get_byte(i_key, i);
        tw[0] = SBOX[k[7]] ^ RC;
        tw[1] = SBOX[k[11]];
        tw[2] = SBOX[k[15]];
        tw[3] = SBOX[k[3]];
        for (int r = 0; r < 4; r++) begin
            nk[4*r] = k[4*r] ^ tw[r];
            for (int c = 1; c < 4; c++) nk[4*r+c] = k[4*r+c] ^ nk[4*r+c-1];
        end
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                ss[4*r+c] = SBOX[get_byte(i_state, 4*r + ((c + r) % 4))];
        for (int c = 0; c < 4; c++) begin
            if (ROUND < ROUNDS) begin
                ms[c]    = ss[c]    ^ ss[4+c] ^ ss[8+c] ^ ss[12+c] ^ ss[c]
                         ^ gf_dbl(ss[c] ^ ss[4+c]);
                ms[4+c]  = ss[c] ^ ss[8+c] ^ ss[12+c] ^ gf_dbl(ss[4+c] ^ ss[8+c]);
                ms[8+c]  = ss[c] ^ ss[4+c] ^ ss[12+c] ^ gf_dbl(ss[8+c] ^ ss[12+c]);
                ms[12+c] = ss[c] ^ ss[4+c] ^ ss[8+c] ^ gf_dbl(ss[12+c] ^ ss[c]);
            end else begin
                ms[c]    = ss[c];
                ms[4+c]  = ss[4+c];
                ms[8+c]  = ss[8+c];
                ms[12+c] = ss[12+c];
            end
        end
        for (int i = 0; i < 16; i++) begin
            n_state[BLOCK_W-1-8*i -: 8] = ms[i] ^ nk[i];
            n_key[BLOCK_W-1-8*i -: 8]   = nk[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_state = r_state;
    assign o_key   = r_key;
endmodule

@@ rtl/aes128_block_encrypt.sv @@
// aes128_block_encrypt: eleven-stage pipelined aes-128 encryption, one round per stage after the key addition stage
// depends on aes_pkg and aes_round
// stages: key addition stage plus ten round stages
// throughput: one item per cycle while not stalled; a stall holds only the full stages, earlier items close bubbles
// the next item is taken while a finished result waits, as long as any stage is free
// reset (synchronous, active low) clears the stage valid bits only
`timescale 1ns / 1ps
module aes128_block_encrypt #(
    parameter int ROUNDS = aes_pkg::NUM_ROUNDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [aes_pkg::FIELD_W-1:0] i_key_hi,
    input  logic [aes_pkg::FIELD_W-1:0] i_key_lo,
    input  logic [aes_pkg::FIELD_W-1:0] i_text_hi,
    input  logic [aes_pkg::FIELD_W-1:0] i_text_lo,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [aes_pkg::FIELD_W-1:0] o_cipher_hi,
    output logic [aes_pkg::FIELD_W-1:0] o_cipher_lo
);
    import aes_pkg::*;

    t_block     st  [ROUNDS+1];
    t_block     ky  [ROUNDS+1];
    logic       en  [ROUNDS+1];
    logic [ROUNDS:0] r_vld;
    logic [ROUNDS:0] n_vld;
    t_block     r_st0;
    t_block     r_ky0;

    // stage s advances when its output slot is free or moving on
    always_comb begin
        en[ROUNDS] = !r_vld[ROUNDS] || !i_stall;
        for (int s = ROUNDS - 1; s >= 0; s--) en[s] = !r_vld[s] || en[s+1];
        n_vld = r_vld;
        for (int s = ROUNDS; s >= 1; s--) if (en[s]) n_vld[s] = r_vld[s-1];
        if (en[0]) n_vld[0] = i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_st0 <= {i_text_hi, i_text_lo} ^ {i_key_hi, i_key_lo};
            r_ky0 <= {i_key_hi, i_key_lo};
        end
    end

    assign st[0] = r_st0;
    assign ky[0] = r_ky0;

    for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
        aes_round #(.ROUND(g), .ROUNDS(ROUNDS)) u_round (
            .i_clk   (i_clk),
            .i_en    (en[g]),
            .i_state (st[g-1]),
            .i_key   (ky[g-1]),
            .o_state (st[g]),
            .o_key   (ky[g])
        );
    end

    assign o_stall     = !en[0];
    assign o_valid     = r_vld[ROUNDS];
    assign o_cipher_hi = st[ROUNDS][BLOCK_W-1:FIELD_W];
    assign o_cipher_lo = st[ROUNDS][FIELD_W-1:0];
endmodule
